FILE: hdl/tcd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tick countdown dispatcher package
// Shared transaction types and codes for the dispatcher.
// ---------------------------------------------------------------------------
package tcd_pkg;

    typedef enum logic [1:0] {
        KIND_PERIODIC  = 2'd0,
        KIND_ONESHOT   = 2'd1,
        KIND_SUSPENDED = 2'd2,
        KIND_STOPPED   = 2'd3
    } t_kind;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [3:0]  slot;
        logic        slot_valid;
        logic [1:0]  slot_kind;
        logic [15:0] reload_in;
        logic [15:0] countdown_in;
    } t_in;

    typedef struct packed {
        logic       ran;
        logic [3:0] ran_slot;
        logic       removed;
        logic       at_head;
    } t_out;

endpackage

FILE: hdl/tcd_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module tcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tick_countdown_task_dispatcher.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tick countdown task dispatcher
// Round-robin dispatcher over a RAM of task slots with countdowns.
// A tick transaction walks the slots in order through S_WALK and S_LAST to
// S_DONE, where its result is given; the walk reads one slot of the task RAM
// per cycle, so the RAM read port sets the rate. A slot write transaction
// goes from acceptance straight to S_DONE. One transaction is in work at a time,
// and a stalled result holds off the input.
// Reset clears the slot valid bits and puts the run pointer at the idle head;
// the task RAM itself is not cleared, the read data of invalid slots is unused.
// ---------------------------------------------------------------------------
module tick_countdown_task_dispatcher
    import tcd_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS + 1);
    localparam int CB = COUNT_BITS;
    localparam int WW = 2 + 2 * CB;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_LAST,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [SLOTS-1:0] r_valid;
    logic [PW-1:0]   r_pos;
    logic [PW-1:0]   r_start;
    logic [PW-1:0]   r_pos_new;
    logic            r_found;
    logic            r_is_tick;
    logic [IW-1:0]   r_idx;
    logic            r_p_vld;
    logic [IW-1:0]   r_p_idx;
    t_out            r_res;
    logic            r_out_valid;
    t_out            r_out;

    logic            accept;
    logic            wr_item;
    logic [IW-1:0]   wr_addr;
    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    logic [WW-1:0]   ram_wdata;
    logic [WW-1:0]   ram_rdata;

    logic [CB-1:0]   cnt;
    logic [CB-1:0]   rel;
    t_kind           kind;
    logic            is_pos;
    logic            slot_live;
    logic [CB-1:0]   n_cnt;
    t_kind           n_kind;
    logic            clr;
    logic            do_ran;
    logic            do_removed;
    logic            out_free;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign wr_addr  = IW'(i_data.slot);
    assign wr_item  = accept && (i_data.mode == MODE_WRITE) && (32'(i_data.slot) < SLOTS);
    assign out_free = !r_out_valid || !i_stall;

    assign kind = t_kind'(ram_rdata[WW-1 -: 2]);
    assign rel  = ram_rdata[2*CB-1 -: CB];
    assign cnt  = ram_rdata[CB-1:0];

    // The slot under the walk becomes the new pointer position when it is the
    // first valid slot at or beyond the search start.
    assign slot_live = r_p_vld && r_valid[r_p_idx];
    assign is_pos    = slot_live && !r_found && (PW'(r_p_idx) >= r_start);

    always_comb begin
        n_cnt      = cnt;
        n_kind     = kind;
        clr        = 1'b0;
        do_ran     = 1'b0;
        do_removed = 1'b0;
        if (is_pos && (cnt == '0)) begin
            case (kind)
                KIND_PERIODIC: begin
                    n_cnt  = rel;
                    do_ran = 1'b1;
                end
                KIND_ONESHOT: begin
                    clr        = 1'b1;
                    do_ran     = 1'b1;
                    do_removed = 1'b1;
                end
                KIND_SUSPENDED: begin
                    n_kind = KIND_PERIODIC;
                end
                default: begin
                end
            endcase
        end
        // A reloaded countdown takes part in the decrement of the same tick.
        if (!clr && (n_cnt != '0)) begin
            n_cnt = n_cnt - 1'b1;
        end
    end

    always_comb begin
        if (slot_live) begin
            ram_we    = 1'b1;
            ram_waddr = r_p_idx;
            ram_wdata = {n_kind, rel, n_cnt};
        end else begin
            ram_we    = wr_item;
            ram_waddr = wr_addr;
            ram_wdata = {i_data.slot_kind, CB'(i_data.reload_in), CB'(i_data.countdown_in)};
        end
    end

    tcd_ram #(
        .WIDTH (WW),
        .DEPTH (SLOTS)
    ) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_pos       <= PW'(SLOTS);
            r_out_valid <= 1'b0;
            r_p_vld     <= 1'b0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_is_tick   <= 1'b0;
        end else begin
            // In the final state a taken result is replaced by the new one below.
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            if (wr_item) begin
                r_valid[wr_addr] <= i_data.slot_valid;
            end

            if (is_pos) begin
                r_found   <= 1'b1;
                r_pos_new <= PW'(r_p_idx);
                if (do_ran) begin
                    r_res.ran      <= 1'b1;
                    r_res.ran_slot <= 4'(r_p_idx);
                    r_res.removed  <= do_removed;
                end
                if (clr) begin
                    r_valid[r_p_idx] <= 1'b0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res     <= '0;
                        r_found   <= 1'b0;
                        r_is_tick <= (i_data.mode == MODE_TICK);
                        r_idx     <= '0;
                        r_start   <= (r_pos >= PW'(SLOTS)) ? '0 : r_pos + 1'b1;
                        r_state   <= (i_data.mode == MODE_TICK) ? S_WALK : S_DONE;
                    end
                end
                S_WALK: begin
                    r_p_vld <= 1'b1;
                    r_p_idx <= r_idx;
                    if (r_idx == IW'(SLOTS - 1)) begin
                        r_state <= S_LAST;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_LAST: begin
                    r_p_vld <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{ran:      r_res.ran,
                                         ran_slot: r_res.ran_slot,
                                         removed:  r_res.removed,
                                         at_head:  r_is_tick && !r_found};
                        if (r_is_tick) begin
                            r_pos <= r_found ? r_pos_new : PW'(SLOTS);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
